>>> sv/jps_pkg.sv
// Package: shared types, constants and the sequencer program for the JPS pruning block.
`default_nettype none
package jps_pkg;

   // storage geometry
   localparam int GRID_DIM = 256;
   localparam int MAP_SIDE = (GRID_DIM < 256) ? GRID_DIM : 256;
   localparam int COL_AW   = $clog2(MAP_SIDE);
   localparam int ROW_AW   = COL_AW;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HEIGHT = 1'b1;
   localparam logic [CSR_DATA_W-1:0] DIM_RESET     = 9'd256;

   // opcodes
   localparam logic [1:0] OP_UPDATE = 2'd0;
   localparam logic [1:0] OP_QUERY  = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   // neighbor offsets, two's complement in two bits
   typedef logic [1:0] off_type;
   localparam off_type OFF_NEG  = 2'b11;
   localparam off_type OFF_ZERO = 2'b00;
   localparam off_type OFF_POS  = 2'b01;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] cell_x;
      logic [7:0] cell_y;
      logic       is_wall;
      logic       has_parent;
      logic [7:0] parent_x;
      logic [7:0] parent_y;
   } req_type;

   typedef struct packed {
      logic [7:0] nbr_x;
      logic [7:0] nbr_y;
      logic       found;
      logic       last;
   } rsp_type;

   // microcode fields
   typedef enum logic [2:0] {
      MEM_NONE, MEM_RD_UP, MEM_RD_Y, MEM_RD_DN, MEM_WR_UPD, MEM_WR_CLR
   } mem_op_type;

   typedef enum logic [1:0] {CAP_NONE, CAP_UP, CAP_MID, CAP_DN} cap_type;

   typedef enum logic [1:0] {EMIT_NONE, EMIT_SLOT, EMIT_EMPTY} emit_type;

   typedef enum logic [2:0] {
      SEQ_NEXT, SEQ_GOTO, SEQ_DISPATCH, SEQ_CLR, SEQ_OOB, SEQ_PLAN, SEQ_EMIT, SEQ_EMPTY
   } seq_type;

   typedef logic [3:0] step_type;

   typedef struct packed {
      logic       rdy;
      mem_op_type mem;
      cap_type    cap;
      logic       plan;
      emit_type   emit;
      seq_type    seq;
      step_type   target;
   } ctrl_type;

   // program addresses
   localparam step_type S_CLR     = 4'd0;
   localparam step_type S_FETCH   = 4'd1;
   localparam step_type S_UPD_RD  = 4'd2;
   localparam step_type S_UPD_WR  = 4'd3;
   localparam step_type S_Q_UP    = 4'd4;
   localparam step_type S_Q_MID   = 4'd5;
   localparam step_type S_Q_DN    = 4'd6;
   localparam step_type S_Q_CAP   = 4'd7;
   localparam step_type S_Q_PLAN  = 4'd8;
   localparam step_type S_Q_EMIT  = 4'd9;
   localparam step_type S_Q_EMPTY = 4'd10;

   // control store
   function automatic ctrl_type rom_word(input step_type step);
      ctrl_type cw;
      cw = '{rdy: 1'b0, mem: MEM_NONE, cap: CAP_NONE, plan: 1'b0,
             emit: EMIT_NONE, seq: SEQ_GOTO, target: S_FETCH};
      unique case (step)
         S_CLR:     begin cw.mem = MEM_WR_CLR; cw.seq = SEQ_CLR;  cw.target = S_FETCH; end
         S_FETCH:   begin cw.rdy = 1'b1;       cw.seq = SEQ_DISPATCH;                  end
         S_UPD_RD:  begin cw.mem = MEM_RD_Y;   cw.seq = SEQ_OOB;  cw.target = S_FETCH; end
         S_UPD_WR:  begin cw.mem = MEM_WR_UPD; cw.seq = SEQ_GOTO; cw.target = S_FETCH; end
         S_Q_UP:    begin cw.mem = MEM_RD_UP;  cw.seq = SEQ_NEXT;                      end
         S_Q_MID:   begin cw.mem = MEM_RD_Y;   cw.cap = CAP_UP;  cw.seq = SEQ_NEXT;    end
         S_Q_DN:    begin cw.mem = MEM_RD_DN;  cw.cap = CAP_MID; cw.seq = SEQ_NEXT;    end
         S_Q_CAP:   begin cw.cap = CAP_DN;     cw.seq = SEQ_NEXT;                      end
         S_Q_PLAN:  begin cw.plan = 1'b1; cw.seq = SEQ_PLAN; cw.target = S_Q_EMPTY;    end
         S_Q_EMIT:  begin cw.emit = EMIT_SLOT;  cw.seq = SEQ_EMIT;  cw.target = S_FETCH; end
         S_Q_EMPTY: begin cw.emit = EMIT_EMPTY; cw.seq = SEQ_EMPTY; cw.target = S_FETCH; end
         default:   begin cw.seq = SEQ_GOTO; cw.target = S_FETCH; end
      endcase
      return cw;
   endfunction

endpackage
`default_nettype wire

>>> sv/jps_req_if.sv
// Interface: request channel carrying one command transaction.
`default_nettype none
interface jps_req_if;
   import jps_pkg::*;

   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/jps_rsp_if.sv
// Interface: response channel carrying one neighbor result transaction.
`default_nettype none
interface jps_rsp_if;
   import jps_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> sv/jps_neighbour_pruning.sv
// Top level: microcoded jump point search neighbor pruning over a one-bit grid map.
//
//  channel | dir | handshake        | payload
//  --------+-----+------------------+------------------------------------------------
//  req_ch  | in  | valid/ready      | opcode, cell_x/y, is_wall, has_parent, parent_x/y
//  rsp_ch  | out | valid/ready      | nbr_x, nbr_y, found, last
//  csr_*   | in  | csr_we (no wait) | csr_index, csr_wdata (map_width, map_height)
//
// Steps: update runs fetch, row read and row write, and skips the write when the cell is
//   out of bounds; clear writes every row of the map, one row per cycle;
//   query runs the three row reads on the single map port, capture and planning, then
//   steps through the candidate slots up to the last listed one, stalling while rsp_ch is held.
// Reset starts a clearing pass over all MAP_SIDE rows with req_ch.ready low;
//   csr writes are taken throughout.
// Stalls: results leave through an output register; a held rsp_ch stalls only the
//   emit steps, and a new transaction is fetched while the last result waits.
`default_nettype none
module jps_neighbour_pruning (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [jps_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [jps_pkg::CSR_DATA_W-1:0]   csr_wdata,
   jps_req_if.sink                          req_ch,
   jps_rsp_if.source                        rsp_ch
);
   import jps_pkg::*;

   localparam logic [CSR_DATA_W-1:0] SIDE_W   = CSR_DATA_W'(MAP_SIDE);
   localparam logic [ROW_AW-1:0]     ROW_LAST = ROW_AW'(MAP_SIDE - 1);

   // ---------------- helpers ----------------
   function automatic logic [9:0] sext10(input off_type o);
      return {{8{o[1]}}, o};
   endfunction

   function automatic logic in_bounds(input logic [9:0] nx, input logic [9:0] ny,
                                      input logic [8:0] lw, input logic [8:0] lh);
      return !nx[9] && (nx[8:0] < lw) && !ny[9] && (ny[8:0] < lh);
   endfunction

   // open bit of the 3x3 window, row-major from the upper left
   function automatic logic open_at(input logic [8:0] o9, input off_type ox,
                                    input off_type oy);
      logic bit_v;
      case ({oy, ox})
         {OFF_NEG,  OFF_NEG }: bit_v = o9[0];
         {OFF_NEG,  OFF_ZERO}: bit_v = o9[1];
         {OFF_NEG,  OFF_POS }: bit_v = o9[2];
         {OFF_ZERO, OFF_NEG }: bit_v = o9[3];
         {OFF_ZERO, OFF_ZERO}: bit_v = o9[4];
         {OFF_ZERO, OFF_POS }: bit_v = o9[5];
         {OFF_POS,  OFF_NEG }: bit_v = o9[6];
         {OFF_POS,  OFF_ZERO}: bit_v = o9[7];
         {OFF_POS,  OFF_POS }: bit_v = o9[8];
         default:              bit_v = 1'b0;
      endcase
      return bit_v;
   endfunction

   // ---------------- registers ----------------
   step_type              step_ff, step_in;
   logic [ROW_AW-1:0]     clr_cnt_ff, clr_cnt_in;
   logic [CSR_DATA_W-1:0] map_width_ff, map_height_ff;

   // latched command
   logic [7:0] x_ff, y_ff;
   logic       wall_ff, parent_ff;
   off_type    dx_ff, dy_ff;

   // window and candidate list
   logic [8:0] open9_ff, open9_in;
   off_type    cand_ox_ff [8];
   off_type    cand_oy_ff [8];
   logic [7:0] cand_en_ff;
   off_type    cand_ox    [8];
   off_type    cand_oy    [8];
   logic [7:0] cand_en;
   logic [2:0] slot_ff, slot_in;

   // output register
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;

   // map memory, one row per entry
   logic [MAP_SIDE-1:0] map_mem [MAP_SIDE];
   logic [MAP_SIDE-1:0] rdata_ff;
   logic [MAP_SIDE-1:0] mem_wdata;
   logic [ROW_AW-1:0]   mem_addr;
   logic                mem_we, mem_re;

   ctrl_type cw;
   logic     accept, out_free, node_inb, slot_last, slot_on;
   logic [8:0] lim_w, lim_h;

   assign cw     = rom_word(step_ff);
   assign accept = req_ch.valid && req_ch.ready;
   assign lim_w  = (map_width_ff  < SIDE_W) ? map_width_ff  : SIDE_W;
   assign lim_h  = (map_height_ff < SIDE_W) ? map_height_ff : SIDE_W;
   assign node_inb = in_bounds({2'b00, x_ff}, {2'b00, y_ff}, lim_w, lim_h);
   assign out_free = !out_valid_ff || rsp_ch.ready;

   assign req_ch.ready = cw.rdy;
   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.data  = out_ff;

   // ---------------- memory port ----------------
   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = y_ff[ROW_AW-1:0];
      mem_wdata = rdata_ff;
      unique case (cw.mem)
         MEM_RD_UP: begin
            mem_re   = 1'b1;
            mem_addr = ROW_AW'(y_ff - 8'd1);
         end
         MEM_RD_Y:  mem_re = 1'b1;
         MEM_RD_DN: begin
            mem_re   = 1'b1;
            mem_addr = ROW_AW'(y_ff + 8'd1);
         end
         MEM_WR_UPD: begin
            mem_we = 1'b1;
            mem_wdata[x_ff[COL_AW-1:0]] = !wall_ff;
         end
         MEM_WR_CLR: begin
            mem_we    = 1'b1;
            mem_addr  = clr_cnt_ff;
            mem_wdata = '1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) map_mem[mem_addr] <= mem_wdata;
      if (mem_re) rdata_ff <= map_mem[mem_addr];
   end

   // ---------------- window capture ----------------
   always_comb begin
      off_type    oy;
      logic [9:0] ny, nx;
      logic [1:0] base;
      open9_in = open9_ff;
      oy   = OFF_ZERO;
      base = 2'd1;
      nx   = '0;
      unique case (cw.cap)
         CAP_UP:  begin oy = OFF_NEG;  base = 2'd0; end
         CAP_MID: begin oy = OFF_ZERO; base = 2'd1; end
         CAP_DN:  begin oy = OFF_POS;  base = 2'd2; end
         default: ;
      endcase
      ny = {2'b00, y_ff} + sext10(oy);
      if (cw.cap != CAP_NONE) begin
         for (int i = 0; i < 3; i++) begin
            nx = {2'b00, x_ff} + 10'(i) - 10'd1;
            open9_in[base * 3 + i] = in_bounds(nx, ny, lim_w, lim_h)
                                     && rdata_ff[nx[COL_AW-1:0]];
         end
      end
   end

   // ---------------- pruning: candidate slots in listing order ----------------
   always_comb begin
      logic    vert, horz, straight;
      off_type ndx, ndy;
      for (int i = 0; i < 8; i++) begin
         cand_ox[i] = OFF_ZERO;
         cand_oy[i] = OFF_ZERO;
      end
      cand_en = '0;
      ndx = OFF_ZERO - dx_ff;
      ndy = OFF_ZERO - dy_ff;
      vert = open_at(open9_ff, OFF_ZERO, dy_ff);
      horz = open_at(open9_ff, dx_ff, OFF_ZERO);
      straight = horz;
      if (!parent_ff) begin
         // all eight neighbors, fixed order
         cand_ox[0] = OFF_NEG;  cand_oy[0] = OFF_ZERO;
         cand_ox[1] = OFF_POS;  cand_oy[1] = OFF_ZERO;
         cand_ox[2] = OFF_ZERO; cand_oy[2] = OFF_POS;
         cand_ox[3] = OFF_ZERO; cand_oy[3] = OFF_NEG;
         cand_ox[4] = OFF_NEG;  cand_oy[4] = OFF_NEG;
         cand_ox[5] = OFF_NEG;  cand_oy[5] = OFF_POS;
         cand_ox[6] = OFF_POS;  cand_oy[6] = OFF_NEG;
         cand_ox[7] = OFF_POS;  cand_oy[7] = OFF_POS;
         for (int i = 0; i < 8; i++)
            cand_en[i] = open_at(open9_ff, cand_ox[i], cand_oy[i]);
      end else if (dx_ff != OFF_ZERO && dy_ff != OFF_ZERO) begin
         // diagonal move
         cand_ox[0] = OFF_ZERO; cand_oy[0] = dy_ff;
         cand_ox[1] = dx_ff;    cand_oy[1] = OFF_ZERO;
         cand_ox[2] = dx_ff;    cand_oy[2] = dy_ff;
         cand_ox[3] = ndx;      cand_oy[3] = dy_ff;
         cand_ox[4] = dx_ff;    cand_oy[4] = ndy;
         cand_en[0] = vert;
         cand_en[1] = horz;
         cand_en[2] = (vert || horz) && open_at(open9_ff, dx_ff, dy_ff);
         cand_en[3] = !open_at(open9_ff, ndx, OFF_ZERO) && vert
                      && open_at(open9_ff, ndx, dy_ff);
         cand_en[4] = !open_at(open9_ff, OFF_ZERO, ndy) && horz
                      && open_at(open9_ff, dx_ff, ndy);
      end else if (dx_ff == OFF_ZERO) begin
         // vertical move, also the parent-on-node case
         cand_ox[0] = OFF_ZERO; cand_oy[0] = dy_ff;
         cand_ox[1] = OFF_POS;  cand_oy[1] = dy_ff;
         cand_ox[2] = OFF_NEG;  cand_oy[2] = dy_ff;
         cand_en[0] = vert;
         cand_en[1] = vert && !open_at(open9_ff, OFF_POS, OFF_ZERO)
                      && open_at(open9_ff, OFF_POS, dy_ff);
         cand_en[2] = vert && !open_at(open9_ff, OFF_NEG, OFF_ZERO)
                      && open_at(open9_ff, OFF_NEG, dy_ff);
      end else begin
         // horizontal move
         cand_ox[0] = dx_ff; cand_oy[0] = OFF_ZERO;
         cand_ox[1] = dx_ff; cand_oy[1] = OFF_POS;
         cand_ox[2] = dx_ff; cand_oy[2] = OFF_NEG;
         cand_en[0] = straight;
         cand_en[1] = straight && !open_at(open9_ff, OFF_ZERO, OFF_POS)
                      && open_at(open9_ff, dx_ff, OFF_POS);
         cand_en[2] = straight && !open_at(open9_ff, OFF_ZERO, OFF_NEG)
                      && open_at(open9_ff, dx_ff, OFF_NEG);
      end
   end

   // ---------------- emit ----------------
   assign slot_on   = cand_en_ff[slot_ff];
   assign slot_last = ~|(cand_en_ff & (8'hFE << slot_ff));

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      slot_in      = slot_ff;
      if (cw.plan) slot_in = 3'd0;
      unique case (cw.emit)
         EMIT_SLOT: begin
            if (!slot_on) begin
               slot_in = slot_ff + 3'd1;
            end else if (out_free) begin
               out_valid_in = 1'b1;
               out_in.nbr_x = x_ff + {{6{cand_ox_ff[slot_ff][1]}}, cand_ox_ff[slot_ff]};
               out_in.nbr_y = y_ff + {{6{cand_oy_ff[slot_ff][1]}}, cand_oy_ff[slot_ff]};
               out_in.found = 1'b1;
               out_in.last  = slot_last;
               slot_in      = slot_ff + 3'd1;
            end
         end
         EMIT_EMPTY: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in       = '{nbr_x: 8'd0, nbr_y: 8'd0, found: 1'b0, last: 1'b1};
            end
         end
         default: ;
      endcase
   end

   // ---------------- sequencer ----------------
   always_comb begin
      step_in    = step_ff + 4'd1;
      clr_cnt_in = clr_cnt_ff;
      unique case (cw.seq)
         SEQ_NEXT: step_in = step_ff + 4'd1;
         SEQ_GOTO: step_in = cw.target;
         SEQ_DISPATCH: begin
            step_in = step_ff;
            if (accept) begin
               unique case (req_ch.data.opcode)
                  OP_UPDATE: step_in = S_UPD_RD;
                  OP_QUERY:  step_in = S_Q_UP;
                  OP_CLEAR:  step_in = S_CLR;
                  default:   step_in = S_FETCH;   // unknown opcode: no effect
               endcase
            end
         end
         SEQ_CLR: begin
            if (clr_cnt_ff == ROW_LAST) begin
               step_in    = cw.target;
               clr_cnt_in = '0;
            end else begin
               step_in    = step_ff;
               clr_cnt_in = clr_cnt_ff + ROW_AW'(1);
            end
         end
         SEQ_OOB:  step_in = node_inb ? step_ff + 4'd1 : cw.target;
         SEQ_PLAN: step_in = (cand_en == 8'd0) ? cw.target : step_ff + 4'd1;
         SEQ_EMIT: step_in = (slot_on && out_free && slot_last) ? cw.target : step_ff;
         SEQ_EMPTY: step_in = out_free ? cw.target : step_ff;
         default:  step_in = S_FETCH;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= S_CLR;
         clr_cnt_ff    <= '0;
         out_valid_ff  <= 1'b0;
         slot_ff       <= 3'd0;
         map_width_ff  <= DIM_RESET;
         map_height_ff <= DIM_RESET;
      end else begin
         step_ff      <= step_in;
         clr_cnt_ff   <= clr_cnt_in;
         out_valid_ff <= out_valid_in;
         slot_ff      <= slot_in;
         if (csr_we) begin
            if (csr_index == CSR_MAP_WIDTH)       map_width_ff  <= csr_wdata;
            else if (csr_index == CSR_MAP_HEIGHT) map_height_ff <= csr_wdata;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      out_ff   <= out_in;
      open9_ff <= open9_in;
      if (accept) begin
         x_ff      <= req_ch.data.cell_x;
         y_ff      <= req_ch.data.cell_y;
         wall_ff   <= req_ch.data.is_wall;
         parent_ff <= req_ch.data.has_parent;
         // move sign of node minus parent
         dx_ff <= (req_ch.data.cell_x > req_ch.data.parent_x) ? OFF_POS :
                  (req_ch.data.cell_x < req_ch.data.parent_x) ? OFF_NEG : OFF_ZERO;
         dy_ff <= (req_ch.data.cell_y > req_ch.data.parent_y) ? OFF_POS :
                  (req_ch.data.cell_y < req_ch.data.parent_y) ? OFF_NEG : OFF_ZERO;
      end
      if (cw.plan) begin
         cand_en_ff <= cand_en;
         for (int i = 0; i < 8; i++) begin
            cand_ox_ff[i] <= cand_ox[i];
            cand_oy_ff[i] <= cand_oy[i];
         end
      end
   end

endmodule
`default_nettype wire

>>> sv/jps_checker.sv
// Checker: port-level assertions for the JPS pruning block, bound to the top level.
`default_nettype none
module jps_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_opcode,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_nbr_x,
   input logic [7:0] rsp_nbr_y,
   input logic       rsp_found,
   input logic       rsp_last
);
   import jps_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_nbr_x) && $stable(rsp_nbr_y)
      && $stable(rsp_found) && $stable(rsp_last))
      else $error("result changed while stalled");

   // an empty result always closes its query
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_last)
      else $error("empty result without last");

   // reset starts the map clearing pass
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during clearing pass");

   // a clear transaction blocks the request side as its sweep begins
   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_opcode == OP_CLEAR) |=> !req_ready)
      else $error("request taken right after clear");

endmodule

bind jps_neighbour_pruning jps_checker u_jps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .req_opcode (req_ch.data.opcode),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_nbr_x  (rsp_ch.data.nbr_x),
   .rsp_nbr_y  (rsp_ch.data.nbr_y),
   .rsp_found  (rsp_ch.data.found),
   .rsp_last   (rsp_ch.data.last)
);
`default_nettype wire
